// ===== sv/lfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// shared types and constants for the lfu cache: payloads, controller state,
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int CSR_W = 5;
   localparam int DATA_W = 32;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};
   localparam logic [DATA_W-1:0] COUNT_MAX = {DATA_W{1'b1}};
   localparam logic [CSR_W-1:0] CAPACITY_RESET = CSR_W'(16);

   typedef struct packed {
      logic              command;
      logic [DATA_W-1:0] lookup_key;
      logic [DATA_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_value;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_SCAN,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic match;
      logic scan_clear;
      logic scan_step;
      logic evict;
      logic insert;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_fill;
      logic scan_last;
      logic over_cap;
      logic out_free;
   } ctl_status_type;

endpackage

// ===== sv/lfu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_ctrl
// sequencer for one access: match, victim scan and evict loop, insert, result
// ----------------------------------------------------------------------------
module lfu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lfu_pkg::ctl_status_type status,
   output lfu_pkg::ctl_cmd_type    cmd
);

   lfu_pkg::state_type state_ff;
   lfu_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         lfu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = lfu_pkg::ST_MATCH;
            end
         end
         lfu_pkg::ST_MATCH: begin
            cmd.match = 1'b1;
            if (status.need_fill) begin
               cmd.scan_clear = 1'b1;
               state_in = lfu_pkg::ST_SCAN;
            end else begin
               state_in = lfu_pkg::ST_FINISH;
            end
         end
         lfu_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = lfu_pkg::ST_CHECK;
            end
         end
         lfu_pkg::ST_CHECK: begin
            // evict one victim per pass until there is room
            if (status.over_cap) begin
               cmd.evict = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in = lfu_pkg::ST_SCAN;
            end else begin
               cmd.insert = 1'b1;
               state_in = lfu_pkg::ST_FINISH;
            end
         end
         lfu_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in = lfu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfu_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/lfu_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_dpath
// entry storage with per-entry count and recency rank, key match, victim scan
// and the result register
// ----------------------------------------------------------------------------
module lfu_dpath #(
   parameter int CAPACITY = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lfu_pkg::req_type               req,
   input  logic                           csr_write_enable,
   input  logic [lfu_pkg::CSR_W-1:0]      csr_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lfu_pkg::rsp_type               rsp,
   input  lfu_pkg::ctl_cmd_type           cmd,
   output lfu_pkg::ctl_status_type        status
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > lfu_pkg::CSR_W) ? CNT_W : lfu_pkg::CSR_W;
   localparam int DW = lfu_pkg::DATA_W;

   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [IW-1:0]         rank_ff  [CAPACITY];
   logic [IW-1:0]         rank_in  [CAPACITY];
   logic [DW-1:0]         key_ff   [CAPACITY];
   logic [DW-1:0]         key_in   [CAPACITY];
   logic [DW-1:0]         value_ff [CAPACITY];
   logic [DW-1:0]         value_in [CAPACITY];
   logic [DW-1:0]         count_ff [CAPACITY];
   logic [DW-1:0]         count_in [CAPACITY];

   logic [lfu_pkg::CSR_W-1:0] capacity_ff;
   lfu_pkg::req_type      req_ff;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic                  hit_ff;
   logic [IW-1:0]         idx_ff;

   logic [IW-1:0]         scan_idx_ff;
   logic                  best_valid_ff;
   logic [IW-1:0]         best_idx_ff;
   logic [DW-1:0]         best_count_ff;
   logic [IW-1:0]         best_rank_ff;
   logic                  free_found_ff;
   logic [IW-1:0]         free_idx_ff;

   logic                  rsp_valid_ff;
   lfu_pkg::rsp_type      rsp_ff, rsp_in;

   logic [CAPACITY-1:0]   match_vec;
   logic                  hit_c;
   logic [IW-1:0]         idx_c;
   logic [CMP_W-1:0]      cap_eff;
   logic                  cap_zero;
   logic                  is_put;
   logic                  touch_en;
   logic                  cand_better;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lfu_pkg::CAPACITY_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   // effective capacity saturates at the storage size
   always_comb begin
      if (CMP_W'(capacity_ff) > CMP_W'(CAPACITY)) begin
         cap_eff = CMP_W'(CAPACITY);
      end else begin
         cap_eff = CMP_W'(capacity_ff);
      end
   end

   assign cap_zero = (capacity_ff == '0);
   assign is_put = (req_ff.command == lfu_pkg::CMD_PUT);

   // parallel key match, keys of valid entries are unique
   always_comb begin
      idx_c = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match_vec[i] = valid_ff[i] && (key_ff[i] == req_ff.lookup_key);
         if (match_vec[i]) begin
            idx_c = idx_c | IW'(i);
         end
      end
      hit_c = |match_vec;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
      end
      if (cmd.match) begin
         hit_ff <= hit_c;
         idx_ff <= idx_c;
      end
   end

   // victim scan: lowest count, ties to the highest rank
   assign cand_better = valid_ff[scan_idx_ff] &&
      (!best_valid_ff || (count_ff[scan_idx_ff] < best_count_ff) ||
       ((count_ff[scan_idx_ff] == best_count_ff) &&
        (rank_ff[scan_idx_ff] > best_rank_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         best_valid_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.scan_clear) begin
         scan_idx_ff <= '0;
         best_valid_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
         if (cand_better) begin
            best_valid_ff <= 1'b1;
         end
         if (!valid_ff[scan_idx_ff]) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && cand_better) begin
         best_idx_ff <= scan_idx_ff;
         best_count_ff <= count_ff[scan_idx_ff];
         best_rank_ff <= rank_ff[scan_idx_ff];
      end
      if (cmd.scan_step && !valid_ff[scan_idx_ff] && !free_found_ff) begin
         free_idx_ff <= scan_idx_ff;
      end
   end

   assign touch_en = hit_ff && !(is_put && cap_zero);

   always_comb begin
      valid_in = valid_ff;
      occ_in = occ_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         rank_in[i] = rank_ff[i];
         key_in[i] = key_ff[i];
         value_in[i] = value_ff[i];
         count_in[i] = count_ff[i];
      end
      if (cmd.evict) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (valid_ff[i] && (rank_ff[i] > rank_ff[best_idx_ff])) begin
               rank_in[i] = rank_ff[i] - 1'b1;
            end
         end
         valid_in[best_idx_ff] = 1'b0;
         rank_in[best_idx_ff] = '0;
         occ_in = occ_ff - 1'b1;
      end else if (cmd.insert) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         valid_in[free_idx_ff] = 1'b1;
         rank_in[free_idx_ff] = '0;
         key_in[free_idx_ff] = req_ff.lookup_key;
         value_in[free_idx_ff] = req_ff.write_value;
         count_in[free_idx_ff] = DW'(1);
         occ_in = occ_ff + 1'b1;
      end else if (cmd.finish && touch_en) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (valid_ff[i] && (rank_ff[i] < rank_ff[idx_ff])) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         rank_in[idx_ff] = '0;
         if (count_ff[idx_ff] != lfu_pkg::COUNT_MAX) begin
            count_in[idx_ff] = count_ff[idx_ff] + 1'b1;
         end
         if (is_put) begin
            value_in[idx_ff] = req_ff.write_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff <= '0;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff <= occ_in;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         key_ff[i] <= key_in[i];
         value_ff[i] <= value_in[i];
         count_ff[i] <= count_in[i];
      end
   end

   always_comb begin
      rsp_in.hit = hit_ff;
      rsp_in.read_value = '0;
      if (is_put) begin
         rsp_in.hit = hit_ff && !cap_zero;
      end else if (hit_ff) begin
         rsp_in.read_value = value_ff[idx_ff];
      end else begin
         rsp_in.read_value = lfu_pkg::MISS_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   assign status.need_fill = is_put && !hit_c && !cap_zero;
   assign status.scan_last = (scan_idx_ff == IW'(CAPACITY - 1));
   assign status.over_cap = (CMP_W'(occ_ff) >= cap_eff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

// ===== sv/lfu_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache
// key-value cache with least-frequently-used replacement, ties broken by
// least recent use
// ----------------------------------------------------------------------------
// req channel carries a get or put item, rsp channel returns one item per
// request: hit flag and read value (value on get hit, all ones on get miss,
// zero for a put). csr_write_enable/csr_write_data set the capacity in use;
// write it only while no item is in flight.
// a get, a put of a present key, or any put with capacity zero goes from
// the match straight to its result. a put of a new key runs one victim
// scan over all CAPACITY entries, plus one more scan per eviction, then
// inserts and gives its result. the scan walks the entries one per cycle
// through a single count/rank comparator.
// one item is in work at a time; the next can be taken in the cycle after
// the previous result is loaded into the output register.
// reset empties the cache and sets capacity to 16. a stalled result holds in
// the output register; the next item is worked up to its result, then waits.
// ----------------------------------------------------------------------------
module lfu_cache #(
   parameter int CAPACITY = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lfu_pkg::req_type          req,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lfu_pkg::rsp_type          rsp,
   input  logic                      csr_write_enable,
   input  logic [lfu_pkg::CSR_W-1:0] csr_write_data
);

   lfu_pkg::ctl_cmd_type    cmd;
   lfu_pkg::ctl_status_type status;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfu_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp              (rsp),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== sv/lfu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_checker
// port-level checks for the lfu cache
// ----------------------------------------------------------------------------
module lfu_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lfu_pkg::rsp_type rsp
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp changed while stalled");

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while busy");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a non-hit result is a get miss or a put
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.hit |->
         (rsp.read_value == lfu_pkg::MISS_VALUE) || (rsp.read_value == '0))
      else $error("bad read value on miss");

endmodule

bind lfu_cache lfu_checker u_lfu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);
